// ===== src/sld_pkg.sv =====
// Package for the sync/length/XOR deframer.
// Holds field widths, result kind codes, register indexes and register reset values.
// No dependencies.
package sld_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 16;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA   = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1,
      CSR_GET_ERROR   = 2'd2,
      CSR_SET_ERROR   = 2'd3
   } csr_index_type;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;   // 'U'
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h7A;   // 'z'
   localparam logic [BYTE_W-1:0] GET_ERROR_RST   = 8'hFF;
   localparam logic [BYTE_W-1:0] SET_ERROR_RST   = 8'hFE;

   typedef enum logic [8:0] {
      PH_HUNT    = 9'b000000001,
      PH_SYNC2   = 9'b000000010,
      PH_CMD     = 9'b000000100,
      PH_LEN_HI  = 9'b000001000,
      PH_LEN_LO  = 9'b000010000,
      PH_SPARE   = 9'b000100000,
      PH_PAYLOAD = 9'b001000000,
      PH_ERRBYTE = 9'b010000000,
      PH_CHECK   = 9'b100000000
   } phase_type;

endpackage

// ===== src/sld_channels.sv =====
// Valid/ready channel interfaces for the deframer: byte input and result output.
// Depends on sld_pkg.
interface sld_req_if;
   import sld_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface sld_rsp_if;
   import sld_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] out_byte;
   logic [BYTE_W-1:0] command;
   logic [LEN_W-1:0]  frame_length;
   modport source (output valid, output kind, output out_byte, output command,
                   output frame_length, input ready);
   modport sink   (input valid, input kind, input out_byte, input command,
                   input frame_length, output ready);
endinterface

// ===== src/sync_length_xor_deframer.sv =====
// Sync/length/XOR deframer top level.
// Depends on sld_pkg and the channel interfaces in sld_channels.sv.
//
// Takes one link byte per transaction and returns at most one result per byte: each
// payload byte as it arrives, then one closing result at the XOR byte (accepted or
// rejected). A byte is taken every cycle while results drain; each byte passes the input
// register and then the result register, between which one byte's whole framing update
// is done. A frame is sync pair, command, 16-bit big-endian length, spare byte, payload,
// XOR byte; error commands give a 5-byte frame with one hidden data byte. The four
// registers (sync pair, two error commands) are written through the csr_ port; the user
// must write them only while the block is idle, which the block itself does not enforce.
module sync_length_xor_deframer (
   input  logic                          clock,
   input  logic                          reset,
   sld_req_if.sink                       req_chan,
   sld_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [sld_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sld_pkg::BYTE_W-1:0]    csr_wdata
);
   import sld_pkg::*;

   // configuration
   logic [BYTE_W-1:0] sync_first_ff, sync_second_ff, get_error_ff, set_error_ff;

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // framing state
   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [BYTE_W-1:0] command_ff, command_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   kind_type          kind_ff, kind_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic [BYTE_W-1:0] out_cmd_ff;
   logic [LEN_W-1:0]  out_len_ff;

   logic              advance, process, emit;
   logic [BYTE_W-1:0] b, xor_with_b;
   logic [LEN_W-1:0]  remain_dec;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign process = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   assign b          = in_byte_ff;
   assign xor_with_b = xor_ff ^ b;
   assign remain_dec = remain_ff - LEN_W'(1);

   always_comb begin
      phase_in    = phase_ff;
      xor_in      = xor_ff;
      command_in  = command_ff;
      length_in   = length_ff;
      remain_in   = remain_ff;
      emit        = 1'b0;
      kind_in     = KIND_DATA;
      out_byte_in = b;
      unique case (phase_ff)
         PH_SYNC2: begin
            if (b == sync_second_ff) begin
               xor_in   = xor_with_b;
               phase_in = PH_CMD;
            end else if (b == sync_first_ff) begin
               xor_in = b;           // restart the pair at this byte
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_CMD: begin
            command_in = b;
            xor_in     = xor_with_b;
            length_in  = '0;
            remain_in  = '0;
            phase_in   = (b == get_error_ff || b == set_error_ff) ? PH_ERRBYTE : PH_LEN_HI;
         end
         PH_LEN_HI: begin
            xor_in    = xor_with_b;
            length_in = {b, BYTE_W'(0)};
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            xor_in    = xor_with_b;
            length_in = {length_ff[LEN_W-1:BYTE_W], b};
            phase_in  = PH_SPARE;
         end
         PH_SPARE: begin
            xor_in    = xor_with_b;
            remain_in = length_ff;
            phase_in  = (length_ff == '0) ? PH_CHECK : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            xor_in    = xor_with_b;
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               phase_in = PH_CHECK;
            end
            emit = 1'b1;
         end
         PH_ERRBYTE: begin
            xor_in   = xor_with_b;
            phase_in = PH_CHECK;
         end
         PH_CHECK: begin
            xor_in   = xor_with_b;
            phase_in = PH_HUNT;
            emit     = 1'b1;
            if (xor_with_b == '0) begin
               kind_in     = KIND_ACCEPT;
               out_byte_in = (length_ff == '0) ? command_ff : '0;
            end else begin
               kind_in     = KIND_REJECT;
               out_byte_in = '0;
            end
         end
         default: begin
            if (b == sync_first_ff) begin
               xor_in   = b;
               phase_in = PH_SYNC2;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   always_comb begin
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (process && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RST;
         sync_second_ff <= SYNC_SECOND_RST;
         get_error_ff   <= GET_ERROR_RST;
         set_error_ff   <= SET_ERROR_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
            CSR_GET_ERROR:   get_error_ff   <= csr_wdata;
            CSR_SET_ERROR:   set_error_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_HUNT;
         xor_ff       <= '0;
         command_ff   <= '0;
         length_ff    <= '0;
         remain_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (process) begin
            phase_ff   <= phase_in;
            xor_ff     <= xor_in;
            command_ff <= command_in;
            length_ff  <= length_in;
            remain_ff  <= remain_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.in_byte;
      end
      if (process && emit) begin
         kind_ff     <= kind_in;
         out_byte_ff <= out_byte_in;
         out_cmd_ff  <= command_ff;
         out_len_ff  <= length_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = kind_ff;
   assign rsp_chan.out_byte     = out_byte_ff;
   assign rsp_chan.command      = out_cmd_ff;
   assign rsp_chan.frame_length = out_len_ff;

   // payload phase always has at least one byte still to come
   a_payload_remaining: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> remain_ff != '0)
      else $error("payload phase with no bytes remaining");

   // a closing result always returns the hunter to the first sync byte
   a_close_to_hunt: assert property (@(posedge clock) disable iff (reset)
      process && phase_ff == PH_CHECK |=> phase_ff == PH_HUNT && out_valid_ff)
      else $error("closing result did not restart hunting");

   // payload results only come from frames with a non-zero length
   a_data_has_length: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && kind_ff == KIND_DATA |-> out_len_ff != '0)
      else $error("payload byte from an empty frame");

   // a rejection never carries a data byte
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && kind_ff == KIND_REJECT |-> out_byte_ff == '0)
      else $error("rejected frame with non-zero data byte");

   // a held input byte is not lost while the result side stalls
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte dropped during stall");

endmodule
